[sv/gde_pkg.sv]
// shared types and constants for the gpio debounce event block
// no dependencies
package gde_pkg;

  localparam int MaskChannels = 8;
  localparam int DebounceW    = 16;
  localparam int TimeW        = 32;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int InDataW      = 48;
  localparam int OutDataW     = 16;
  localparam int ChanFieldW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce = 3'd0,
    CfgInvert   = 3'd1,
    CfgEnable   = 3'd2,
    CfgOutput   = 3'd3,
    CfgReport   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OpSample  = 1'b0,
    OpCommand = 1'b1
  } op_e;

  typedef enum logic {
    KindReport = 1'b0,
    KindDrive  = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StFlush  = 5'b00100,
    StCmd    = 5'b01000,
    StCmdOut = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic [DebounceW-1:0]    debounce_ms;
    logic                    invert;
    logic [MaskChannels-1:0] enable_mask;
    logic [MaskChannels-1:0] output_mask;
    logic [MaskChannels-1:0] report_mask;
  } cfg_t;

  typedef struct packed {
    logic             rep;
    logic             pend;
    logic [TimeW-1:0] since;
  } chan_rd_t;

  typedef struct packed {
    logic             rep_we;
    logic             rep;
    logic             pend_we;
    logic             pend;
    logic [TimeW-1:0] since;
  } chan_wr_t;

endpackage

[sv/gde_chan_store.sv]
// per-channel debounce state: reported level, pending level, pending timestamp
// depends on gde_pkg
module gde_chan_store #(
  parameter int NumChan = 8,
  parameter int IdxW    = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IdxW-1:0]     rd_idx_i,
  output gde_pkg::chan_rd_t   rd_o,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  gde_pkg::chan_wr_t   wr_i,
  output logic [NumChan-1:0]  rep_levels_o
);
  import gde_pkg::*;

  logic [NumChan-1:0] rep_q, rep_d;
  logic [NumChan-1:0] pend_q, pend_d;
  logic [TimeW-1:0]   since_q [NumChan];

  always_comb begin
    rep_d  = rep_q;
    pend_d = pend_q;
    if (wr_i.rep_we) begin
      rep_d[wr_idx_i] = wr_i.rep;
    end
    if (wr_i.pend_we) begin
      pend_d[wr_idx_i] = wr_i.pend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q  <= '0;
      pend_q <= '0;
      for (int c = 0; c < NumChan; c++) begin
        since_q[c] <= '0;
      end
    end else begin
      rep_q  <= rep_d;
      pend_q <= pend_d;
      if (wr_i.pend_we) begin
        since_q[wr_idx_i] <= wr_i.since;
      end
    end
  end

  assign rd_o.rep     = rep_q[rd_idx_i];
  assign rd_o.pend    = pend_q[rd_idx_i];
  assign rd_o.since   = since_q[rd_idx_i];
  assign rep_levels_o = rep_q;

endmodule

[sv/gde_engine.sv]
// sequencer with shared time-difference unit, report holding stage and output register
// depends on gde_pkg and drives gde_chan_store through its ports
module gde_engine #(
  parameter int NumChan = 8,
  parameter int IdxW    = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gde_pkg::cfg_t                  cfg_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [gde_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [gde_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tuser_o,
  output logic [IdxW-1:0]                rd_idx_o,
  input  gde_pkg::chan_rd_t              rd_i,
  output logic [IdxW-1:0]                wr_idx_o,
  output gde_pkg::chan_wr_t              wr_o,
  input  logic [NumChan-1:0]             rep_levels_i
);
  import gde_pkg::*;

  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(NumChan - 1);
  localparam logic [ChanFieldW:0] NumChanW = (ChanFieldW + 1)'(NumChan);

  seq_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [TimeW-1:0]        now_q;
  logic [MaskChannels-1:0] pins_q;
  logic [ChanFieldW-1:0]   cch_q;
  logic                    cval_q;

  logic            held_valid_q, held_valid_d;
  logic [IdxW-1:0] held_ch_q, held_ch_d;
  logic            held_lvl_q, held_lvl_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_kind_q, out_kind_d;
  logic [ChanFieldW-1:0]   out_ch_q, out_ch_d;
  logic                    out_lvl_q, out_lvl_d;
  logic [MaskChannels-1:0] out_drv_q, out_drv_d;
  logic                    out_last_q, out_last_d;

  logic                    accept;
  logic                    can_push;
  logic                    eligible;
  logic                    lvl;
  logic [TimeW-1:0]        new_since;
  logic [TimeW-1:0]        diff;
  logic                    settle;
  logic                    cmd_ok;
  logic [MaskChannels-1:0] drive;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign can_push        = !out_valid_q || m_axis_tready_i;

  // shared debounce check for the channel under the scan pointer
  assign eligible  = cfg_i.enable_mask[idx_q] && !cfg_i.output_mask[idx_q]
                     && cfg_i.report_mask[idx_q];
  assign lvl       = pins_q[idx_q] ^ cfg_i.invert;
  assign new_since = (lvl != rd_i.pend) ? now_q : rd_i.since;
  assign diff      = now_q - new_since;
  assign settle    = eligible && (lvl != rd_i.rep)
                     && (diff >= {{(TimeW-DebounceW){1'b0}}, cfg_i.debounce_ms});

  assign cmd_ok = ({1'b0, cch_q} < NumChanW) && cfg_i.enable_mask[cch_q]
                  && cfg_i.output_mask[cch_q];

  always_comb begin
    drive = '0;
    for (int c = 0; c < NumChan; c++) begin
      drive[c] = cfg_i.enable_mask[c] & cfg_i.output_mask[c]
                 & (rep_levels_i[c] ^ cfg_i.invert);
    end
  end

  assign rd_idx_o = idx_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    held_valid_d = held_valid_q;
    held_ch_d    = held_ch_q;
    held_lvl_d   = held_lvl_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_ch_d     = out_ch_q;
    out_lvl_d    = out_lvl_q;
    out_drv_d    = out_drv_q;
    out_last_d   = out_last_q;
    wr_idx_o     = idx_q;
    wr_o         = '0;
    wr_o.since   = now_q;
    wr_o.pend    = lvl;
    wr_o.rep     = lvl;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d        = '0;
          held_valid_d = 1'b0;
          state_d      = (s_axis_tuser_i == OpSample) ? StScan : StCmd;
        end
      end
      StScan: begin
        if (!(settle && held_valid_q && !can_push)) begin
          wr_o.pend_we = eligible;
          wr_o.since   = new_since;
          wr_o.rep_we  = settle;
          if (settle) begin
            if (held_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = KindReport;
              out_ch_d    = ChanFieldW'(held_ch_q);
              out_lvl_d   = held_lvl_q;
              out_drv_d   = drive;
              out_last_d  = 1'b0;
            end
            held_valid_d = 1'b1;
            held_ch_d    = idx_q;
            held_lvl_d   = lvl;
          end
          if (idx_q == LastIdx) begin
            state_d = StFlush;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      StFlush: begin
        if (!held_valid_q) begin
          state_d = StIdle;
        end else if (can_push) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KindReport;
          out_ch_d     = ChanFieldW'(held_ch_q);
          out_lvl_d    = held_lvl_q;
          out_drv_d    = drive;
          out_last_d   = 1'b1;
          held_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      StCmd: begin
        wr_idx_o    = IdxW'(cch_q);
        wr_o.rep    = cval_q;
        wr_o.rep_we = cmd_ok;
        state_d     = cmd_ok ? StCmdOut : StIdle;
      end
      StCmdOut: begin
        if (can_push) begin
          out_valid_d = 1'b1;
          out_kind_d  = KindDrive;
          out_ch_d    = cch_q;
          out_lvl_d   = cval_q;
          out_drv_d   = drive;
          out_last_d  = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= s_axis_tdata_i[31:0];
      pins_q <= s_axis_tdata_i[39:32];
      cch_q  <= s_axis_tdata_i[42:40];
      cval_q <= s_axis_tdata_i[43];
    end
    held_ch_q  <= held_ch_d;
    held_lvl_q <= held_lvl_d;
    out_kind_q <= out_kind_d;
    out_ch_q   <= out_ch_d;
    out_lvl_q  <= out_lvl_d;
    out_drv_q  <= out_drv_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_drv_q, out_lvl_q, out_ch_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

[sv/gpio_debounce_event_block.sv]
// gpio debounce event block: config registers, channel state, scan sequencer
// a sample word is accepted, scanned one channel at a time (up to eight), then flushed
// a command word runs StCmd, then StCmdOut if valid; scan unit and output register set the pace
// reports leave one per cycle while the scan runs unless the output side stalls
// reset (asynchronous, active low) clears all channel state and loads register defaults
// depends on gde_pkg, gde_chan_store, gde_engine
module gpio_debounce_event_block #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gde_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gde_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_ms[31:0], pin_levels[39:32], command_channel[42:40], command_value[43], zero pad
  input  logic [gde_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op
  input  logic                          s_axis_tuser_i,
  // result words
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // channel[2:0], level[3], drive_levels[11:4], zero pad
  output logic [gde_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // kind
  output logic                          m_axis_tuser_o
);
  import gde_pkg::*;

  localparam int NumChan = (CHANNELS < MaskChannels) ? CHANNELS : MaskChannels;
  localparam int IdxW    = (NumChan > 1) ? $clog2(NumChan) : 1;

  cfg_t cfg_q, cfg_d;

  logic [IdxW-1:0]    rd_idx;
  logic [IdxW-1:0]    wr_idx;
  chan_rd_t           rd;
  chan_wr_t           wr;
  logic [NumChan-1:0] rep_levels;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounce: cfg_d.debounce_ms = cfg_data_i;
        CfgInvert:   cfg_d.invert      = cfg_data_i[0];
        CfgEnable:   cfg_d.enable_mask = cfg_data_i[7:0];
        CfgOutput:   cfg_d.output_mask = cfg_data_i[7:0];
        CfgReport:   cfg_d.report_mask = cfg_data_i[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= 16'd20;
      cfg_q.invert      <= 1'b0;
      cfg_q.enable_mask <= 8'hff;
      cfg_q.output_mask <= 8'h00;
      cfg_q.report_mask <= 8'hff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gde_chan_store #(
    .NumChan (NumChan),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_idx_i     (rd_idx),
    .rd_o         (rd),
    .wr_idx_i     (wr_idx),
    .wr_i         (wr),
    .rep_levels_o (rep_levels)
  );

  gde_engine #(
    .NumChan (NumChan),
    .IdxW    (IdxW)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .rd_idx_o        (rd_idx),
    .rd_i            (rd),
    .wr_idx_o        (wr_idx),
    .wr_o            (wr),
    .rep_levels_i    (rep_levels)
  );

endmodule
